/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// Assertions compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed: lbl");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error("assertion failed: lbl");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/jrdd_pkg.sv */
// Shared types, constants and helpers for the ramped differential drive mixer.
// No dependencies.
`timescale 1ns / 1ps
package jrdd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_GAIN   = 3'd5;

  // reset values
  localparam logic [7:0]  DEADBAND_RST   = 8'd12;
  localparam logic [13:0] FAST_STEP_RST  = 14'd512;
  localparam logic [13:0] SLOW_STEP_RST  = 14'd205;
  localparam logic [13:0] BRAKE_STEP_RST = 14'd2688;
  localparam logic [15:0] FAST_LIMIT_RST = 16'd13709;
  localparam logic [7:0]  TURN_GAIN_RST  = 8'd90;

  // link status codes
  localparam logic [1:0] LINK_FRESH = 2'd0;
  localparam logic [1:0] LINK_HOLD  = 2'd1;

  // full scale in Q.8
  localparam logic signed [16:0] RAMP_MAX = 17'sd65280;
  localparam logic signed [18:0] SIDE_MAX = 19'sd65280;

  typedef struct packed {
    logic [13:0] fast_step;
    logic [13:0] slow_step;
    logic [13:0] brake_step;
    logic [15:0] fast_limit;
  } ramp_cfg_t;

  typedef struct packed {
    logic [7:0] fwd;
    logic [7:0] rev;
  } duty_pair_t;

  // saturate a Q.8 side value to full scale and split into duties
  function automatic duty_pair_t side_split(input logic signed [18:0] s);
    logic signed [18:0] sat;
    logic [18:0]        mag;
    duty_pair_t         r;
    sat = s;
    if (s > SIDE_MAX) sat = SIDE_MAX;
    if (s < -SIDE_MAX) sat = -SIDE_MAX;
    mag = sat[18] ? 19'(-sat) : 19'(sat);
    r.fwd = 8'd0;
    r.rev = 8'd0;
    if (sat[18]) r.rev = mag[15:8];
    else         r.fwd = mag[15:8];
    return r;
  endfunction

endpackage

/* rtl/jrdd_axis_map.sv */
// Maps one raw stick axis to a signed whole-number target with deadband.
// Depends on jrdd_pkg.
`timescale 1ns / 1ps
module jrdd_axis_map (
  input  logic [15:0]       raw_i,
  input  logic [7:0]        deadband_i,
  output logic signed [8:0] target_o
);
  import jrdd_pkg::*;

  localparam logic [25:0] AxisOffset = 26'd16711425; // 255 * 65535

  logic [24:0]        scaled;
  logic signed [25:0] n;
  logic [23:0]        mag;
  logic [24:0]        mag_sum;
  logic [8:0]         q_est;
  logic [24:0]        rem;
  logic [7:0]         q;
  logic [23:0]        thresh;

  // raw * 510
  assign scaled = {raw_i, 9'b0} - {8'b0, raw_i, 1'b0};
  assign n      = signed'(AxisOffset) - signed'({1'b0, scaled});
  assign mag    = n[25] ? 24'(-n) : n[23:0];

  // divide by 65535: estimate low by at most one, then correct
  assign mag_sum = {1'b0, mag} + {17'b0, mag[23:16]};
  assign q_est   = mag_sum[24:16];
  assign rem     = {1'b0, mag} - {q_est, 16'b0} + {16'b0, q_est};
  assign q       = 8'(q_est + {8'b0, (rem >= 25'd65535)});

  // deadband * 65535
  assign thresh = {deadband_i, 16'b0} - {16'b0, deadband_i};

  always_comb begin
    if (mag <= thresh) begin
      target_o = 9'sd0;
    end else if (n[25]) begin
      target_o = -signed'({1'b0, q});
    end else begin
      target_o = signed'({1'b0, q});
    end
  end

endmodule

/* rtl/jrdd_ramp.sv */
// Slew-rate limiter for one axis: next ramp value from current value and target.
// Depends on jrdd_pkg.
`timescale 1ns / 1ps
module jrdd_ramp (
  input  jrdd_pkg::ramp_cfg_t cfg_i,
  input  logic signed [16:0]  cur_i,
  input  logic signed [8:0]   target_i,
  output logic signed [16:0]  next_o
);
  import jrdd_pkg::*;

  logic signed [18:0] c, t, lim, fast, slow, decel, s, nxt;

  assign c     = 19'(cur_i);
  assign t     = 19'(signed'({target_i, 8'b0}));
  assign lim   = signed'({3'b0, cfg_i.fast_limit});
  assign fast  = signed'({5'b0, cfg_i.fast_step});
  assign slow  = signed'({5'b0, cfg_i.slow_step});
  assign decel = signed'({5'b0, cfg_i.brake_step});

  always_comb begin
    s   = c;
    nxt = c;
    if (t == 19'sd0) begin
      if (c > 19'sd0) begin
        s   = c - decel;
        nxt = (s < 19'sd0) ? 19'sd0 : s;
      end else if (c < 19'sd0) begin
        s   = c + decel;
        nxt = (s > 19'sd0) ? 19'sd0 : s;
      end
    end else if (t > 19'sd0) begin
      if (c < t) begin
        s   = c + ((c < lim) ? fast : slow);
        nxt = (s > t) ? t : s;
      end else begin
        s   = c - decel;
        nxt = (s < t) ? t : s;
      end
    end else begin
      if (c > t) begin
        s   = c - ((c > -lim) ? fast : slow);
        nxt = (s < t) ? t : s;
      end else begin
        s   = c + decel;
        nxt = (s > t) ? t : s;
      end
    end
  end

  // clamped result stays within full scale
  assign next_o = nxt[16:0];

endmodule

/* rtl/jrdd_mixer.sv */
// Differential mixer: negated ramps, scaled turn term, saturation and duty split.
// Depends on jrdd_pkg.
`timescale 1ns / 1ps
module jrdd_mixer (
  input  logic signed [16:0]  ramp_lin_i,
  input  logic signed [16:0]  ramp_ang_i,
  input  logic [7:0]          turn_gain_i,
  output jrdd_pkg::duty_pair_t left_o,
  output jrdd_pkg::duty_pair_t right_o
);
  import jrdd_pkg::*;

  logic signed [17:0] lin, ang;
  logic signed [26:0] prod;
  logic [26:0]        pmag;
  logic signed [18:0] term_mag, term, left, right;

  assign lin  = -18'(ramp_lin_i);
  assign ang  = -18'(ramp_ang_i);
  assign prod = ang * signed'({1'b0, turn_gain_i});
  assign pmag = prod[26] ? 27'(-prod) : 27'(prod);

  // truncate toward zero
  assign term_mag = signed'({2'b0, pmag[24:8]});
  assign term     = prod[26] ? -term_mag : term_mag;

  assign left  = 19'(lin) - term;
  assign right = 19'(lin) + term;

  assign left_o  = side_split(left);
  assign right_o = side_split(right);

endmodule

/* rtl/joystick_ramped_differential_drive.sv */
// Ramped differential drive mixer, top level: config registers, pipeline, assertions.
// Depends on jrdd_pkg, jrdd_axis_map, jrdd_ramp, jrdd_mixer, assert_macros.svh.
`timescale 1ns / 1ps
// One transaction per clock tick in steady state; a result passes the input
// register, which loads on the accepting edge, then the ramp state register,
// then the output register. The throughput is set by the ramp state update, a
// single add and clamp per axis, so an input is taken every cycle as long as
// the output side keeps taking results. Stick axes are mapped to targets as
// they enter, the ramps advance when an item moves into the ramp stage, and
// the mixer fills the output register. Configuration writes are always taken
// (cfg_ready_o is tied high) and must happen while the pipeline is empty.
`include "assert_macros.svh"

module joystick_ramped_differential_drive (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [jrdd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [jrdd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [15:0]                     stick_vertical_i,
  input  logic [15:0]                     stick_horizontal_i,
  input  logic [1:0]                      link_status_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      left_forward_duty_o,
  output logic [7:0]                      left_reverse_duty_o,
  output logic [7:0]                      right_forward_duty_o,
  output logic [7:0]                      right_reverse_duty_o
);
  import jrdd_pkg::*;

  // configuration
  logic [7:0] deadband_q, turn_gain_q;
  ramp_cfg_t  ramp_cfg_q;

  // input stage
  logic              s1_valid_q;
  logic signed [8:0] s1_tgt_lin_q, s1_tgt_ang_q;
  logic [1:0]        s1_status_q;
  logic signed [8:0] map_lin, map_ang;

  // ramp stage (holds the block state)
  logic              s2_valid_q;
  logic signed [8:0] target_lin_q, target_ang_q;
  logic signed [8:0] target_lin_d, target_ang_d;
  logic signed [16:0] ramp_lin_q, ramp_ang_q, ramp_lin_d, ramp_ang_d;

  // output stage
  logic       out_valid_q;
  duty_pair_t left_q, right_q, left_d, right_d;

  logic s1_adv, out_adv, s2_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deadband_q            <= DEADBAND_RST;
      turn_gain_q           <= TURN_GAIN_RST;
      ramp_cfg_q.fast_step  <= FAST_STEP_RST;
      ramp_cfg_q.slow_step  <= SLOW_STEP_RST;
      ramp_cfg_q.brake_step <= BRAKE_STEP_RST;
      ramp_cfg_q.fast_limit <= FAST_LIMIT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DEADBAND:   deadband_q            <= cfg_data_i[7:0];
        CFG_FAST_STEP:  ramp_cfg_q.fast_step  <= cfg_data_i[13:0];
        CFG_SLOW_STEP:  ramp_cfg_q.slow_step  <= cfg_data_i[13:0];
        CFG_BRAKE_STEP: ramp_cfg_q.brake_step <= cfg_data_i[13:0];
        CFG_FAST_LIMIT: ramp_cfg_q.fast_limit <= cfg_data_i;
        CFG_TURN_GAIN:  turn_gain_q           <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // handshake chain
  assign out_adv    = s2_valid_q && (!out_valid_q || out_ready_i);
  assign s2_ready   = !s2_valid_q || out_adv;
  assign s1_adv     = s1_valid_q && s2_ready;
  assign in_ready_o = !s1_valid_q || s1_adv;

  jrdd_axis_map u_map_lin (
    .raw_i      (stick_vertical_i),
    .deadband_i (deadband_q),
    .target_o   (map_lin)
  );

  jrdd_axis_map u_map_ang (
    .raw_i      (stick_horizontal_i),
    .deadband_i (deadband_q),
    .target_o   (map_ang)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_tgt_lin_q <= map_lin;
      s1_tgt_ang_q <= map_ang;
      s1_status_q  <= link_status_i;
    end
  end

  // target select: fresh, hold, or disconnected
  always_comb begin
    case (s1_status_q)
      LINK_FRESH: begin
        target_lin_d = s1_tgt_lin_q;
        target_ang_d = s1_tgt_ang_q;
      end
      LINK_HOLD: begin
        target_lin_d = target_lin_q;
        target_ang_d = target_ang_q;
      end
      default: begin
        target_lin_d = 9'sd0;
        target_ang_d = 9'sd0;
      end
    endcase
  end

  jrdd_ramp u_ramp_lin (
    .cfg_i    (ramp_cfg_q),
    .cur_i    (ramp_lin_q),
    .target_i (target_lin_d),
    .next_o   (ramp_lin_d)
  );

  jrdd_ramp u_ramp_ang (
    .cfg_i    (ramp_cfg_q),
    .cur_i    (ramp_ang_q),
    .target_i (target_ang_d),
    .next_o   (ramp_ang_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q   <= 1'b0;
      target_lin_q <= 9'sd0;
      target_ang_q <= 9'sd0;
      ramp_lin_q   <= 17'sd0;
      ramp_ang_q   <= 17'sd0;
    end else if (s1_adv) begin
      s2_valid_q   <= 1'b1;
      target_lin_q <= target_lin_d;
      target_ang_q <= target_ang_d;
      ramp_lin_q   <= ramp_lin_d;
      ramp_ang_q   <= ramp_ang_d;
    end else if (out_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  jrdd_mixer u_mixer (
    .ramp_lin_i  (ramp_lin_q),
    .ramp_ang_i  (ramp_ang_q),
    .turn_gain_i (turn_gain_q),
    .left_o      (left_d),
    .right_o     (right_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign left_forward_duty_o  = left_q.fwd;
  assign left_reverse_duty_o  = left_q.rev;
  assign right_forward_duty_o = right_q.fwd;
  assign right_reverse_duty_o = right_q.rev;

  // ramp state moves only when an item enters the ramp stage
  `ASSERT_PROP(a_ramp_hold, clk_i, rst_ni, !s1_adv |=> ($stable(ramp_lin_q) && $stable(ramp_ang_q)))
  // ramps never pass full scale
  `ASSERT_NEVER(a_lin_range, clk_i, rst_ni, (ramp_lin_q > RAMP_MAX) || (ramp_lin_q < -RAMP_MAX))
  `ASSERT_NEVER(a_ang_range, clk_i, rst_ni, (ramp_ang_q > RAMP_MAX) || (ramp_ang_q < -RAMP_MAX))
  // a side drives one direction at a time
  `ASSERT_NEVER(a_left_dir, clk_i, rst_ni, out_valid_q && (|left_q.fwd) && (|left_q.rev))
  `ASSERT_NEVER(a_right_dir, clk_i, rst_ni, out_valid_q && (|right_q.fwd) && (|right_q.rev))

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for joystick_ramped_differential_drive: a queue-fed stick driver,
// a duty monitor and a transaction-level predictor of the targets, ramps and wheel mixer.
// Depends on jrdd_pkg and the mixer RTL.
module tb;
  import jrdd_pkg::*;

  localparam logic [1:0] LINK_LOST  = 2'd2;
  localparam logic [1:0] LINK_SPARE = 2'd3;  // unused code, behaves as lost
  localparam int AXIS_SPAN    = 65535;
  localparam int FULL_SCALE   = 255 * 256;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int SHOW_LIMIT   = 10;

  typedef struct packed {
    logic [15:0] vert;
    logic [15:0] horiz;
    logic [1:0]  link;
  } stick_t;

  typedef struct packed {
    logic [7:0] lf;
    logic [7:0] lr;
    logic [7:0] rf;
    logic [7:0] rr;
  } duty_set_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [15:0]           stick_vertical_i = '0;
  logic [15:0]           stick_horizontal_i = '0;
  logic [1:0]            link_status_i = LINK_FRESH;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [7:0]            left_forward_duty_o;
  logic [7:0]            left_reverse_duty_o;
  logic [7:0]            right_forward_duty_o;
  logic [7:0]            right_reverse_duty_o;

  joystick_ramped_differential_drive dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .stick_vertical_i     (stick_vertical_i),
    .stick_horizontal_i   (stick_horizontal_i),
    .link_status_i        (link_status_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .left_forward_duty_o  (left_forward_duty_o),
    .left_reverse_duty_o  (left_reverse_duty_o),
    .right_forward_duty_o (right_forward_duty_o),
    .right_reverse_duty_o (right_reverse_duty_o)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the registers and the drive state
  logic [7:0]         deadband_q   = DEADBAND_RST;
  logic [13:0]        fast_step_q  = FAST_STEP_RST;
  logic [13:0]        slow_step_q  = SLOW_STEP_RST;
  logic [13:0]        brake_step_q = BRAKE_STEP_RST;
  logic [15:0]        fast_limit_q = FAST_LIMIT_RST;
  logic [7:0]         turn_gain_q  = TURN_GAIN_RST;
  logic signed [8:0]  lin_target   = '0;
  logic signed [8:0]  ang_target   = '0;
  logic signed [16:0] lin_ramp     = '0;
  logic signed [16:0] ang_ramp     = '0;

  stick_t    stick_queue[$];
  duty_set_t duty_forecast[$];
  stick_t    on_wire;

  int fail_count = 0;
  int sticks_taken = 0;
  int duties_checked = 0;
  int cfg_writes = 0;
  int saturated_sides = 0;
  int ramp_peak = 0;
  int send_gap = 0, send_calm = 0;
  int recv_gap = 0, recv_calm = 0;
  int stall_cycles = 0;

  function automatic logic signed [8:0] axis_target(input logic [15:0] raw);
    int r, n, mag, db, q;
    r = raw;
    db = deadband_q;
    n = 255 * AXIS_SPAN - r * 510;
    mag = (n < 0) ? -n : n;
    if (mag <= db * AXIS_SPAN) return '0;
    q = mag / AXIS_SPAN;
    return (n < 0) ? 9'(-q) : 9'(q);
  endfunction

  function automatic logic signed [16:0] ramp_step(input logic signed [16:0] now,
                                                  input logic signed [8:0] goal);
    int cur, tgt, lim, fs, ss, ds;
    cur = now;
    tgt = goal;
    tgt = tgt * 256;
    lim = fast_limit_q;
    fs = fast_step_q;
    ss = slow_step_q;
    ds = brake_step_q;
    if (tgt == 0) begin
      if (cur > 0) begin
        cur = cur - ds;
        if (cur < 0) cur = 0;
      end else if (cur < 0) begin
        cur = cur + ds;
        if (cur > 0) cur = 0;
      end
    end else if (tgt > 0) begin
      // below a positive goal it accelerates, even from the negative side
      if (cur < tgt) begin
        cur = cur + ((cur < lim) ? fs : ss);
        if (cur > tgt) cur = tgt;
      end else begin
        cur = cur - ds;
        if (cur < tgt) cur = tgt;
      end
    end else begin
      if (cur > tgt) begin
        cur = cur - ((cur > -lim) ? fs : ss);
        if (cur < tgt) cur = tgt;
      end else begin
        cur = cur + ds;
        if (cur > tgt) cur = tgt;
      end
    end
    return 17'(cur);
  endfunction

  // {forward, reverse} duty of one wheel
  function automatic logic [15:0] wheel_duty(input int side);
    int s;
    s = side;
    if (s > FULL_SCALE) s = FULL_SCALE;
    if (s < -FULL_SCALE) s = -FULL_SCALE;
    if (s > 0) return {8'(s >> 8), 8'd0};
    if (s < 0) return {8'd0, 8'((-s) >> 8)};
    return 16'd0;
  endfunction

  task automatic advance_drive(input stick_t s);
    int lin, ang, g, term, left, right;
    duty_set_t d;
    if (s.link == LINK_FRESH) begin
      lin_target = axis_target(s.vert);
      ang_target = axis_target(s.horiz);
    end else if (s.link != LINK_HOLD) begin
      lin_target = '0;
      ang_target = '0;
    end
    lin_ramp = ramp_step(lin_ramp, lin_target);
    ang_ramp = ramp_step(ang_ramp, ang_target);
    lin = lin_ramp;
    ang = ang_ramp;
    lin = -lin;
    ang = -ang;
    g = turn_gain_q;
    term = (ang * g) / 256;
    left = lin - term;
    right = lin + term;
    if (left > FULL_SCALE || left < -FULL_SCALE) saturated_sides++;
    if (right > FULL_SCALE || right < -FULL_SCALE) saturated_sides++;
    if (lin > ramp_peak) ramp_peak = lin;
    if (-lin > ramp_peak) ramp_peak = -lin;
    {d.lf, d.lr} = wheel_duty(left);
    {d.rf, d.rr} = wheel_duty(right);
    duty_forecast.push_back(d);
  endtask

  task automatic check_duties(input duty_set_t got);
    duty_set_t want;
    if (duty_forecast.size() == 0) begin
      fail_count++;
      if (fail_count <= SHOW_LIMIT)
        $display("ERROR: %0t duty set with nothing pending: %0d/%0d/%0d/%0d", $realtime,
                 got.lf, got.lr, got.rf, got.rr);
    end else begin
      want = duty_forecast.pop_front();
      if (got.lf !== want.lf || got.lr !== want.lr || got.rf !== want.rf ||
          got.rr !== want.rr) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT)
          $display("ERROR: %0t duty set %0d expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   $realtime, duties_checked, want.lf, want.lr, want.rf, want.rr,
                   got.lf, got.lr, got.rf, got.rr);
      end
      duties_checked++;
    end
  endtask

  // mostly short gaps, a few long ones, and calm stretches with none
  task automatic draw_gap(inout int calm, output int gap);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (r < 3) begin
      calm = $urandom_range(20, 80);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 93) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(8, 40);
    end
  endtask

  // stick driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_drive(on_wire);
        sticks_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (stick_queue.size() > 0) begin
          on_wire = stick_queue.pop_front();
          stick_vertical_i <= on_wire.vert;
          stick_horizontal_i <= on_wire.horiz;
          link_status_i <= on_wire.link;
          in_valid_i <= 1'b1;
          draw_gap(send_calm, send_gap);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // duty monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        check_duties({left_forward_duty_o, left_reverse_duty_o,
                      right_forward_duty_o, right_reverse_duty_o});
      if (recv_gap > 0) begin
        recv_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        draw_gap(recv_calm, recv_gap);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles, %0d duty sets pending",
               IDLE_LIMIT, duty_forecast.size());
      $display("** joystick_ramped_differential_drive: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_DEADBAND:   deadband_q = val[7:0];
      CFG_FAST_STEP:  fast_step_q = val[13:0];
      CFG_SLOW_STEP:  slow_step_q = val[13:0];
      CFG_BRAKE_STEP: brake_step_q = val[13:0];
      CFG_FAST_LIMIT: fast_limit_q = val;
      CFG_TURN_GAIN:  turn_gain_q = val[7:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic load_setting(input logic [15:0] db, input logic [15:0] fs,
                              input logic [15:0] ss, input logic [15:0] ds,
                              input logic [15:0] fl, input logic [15:0] tg);
    write_reg(CFG_DEADBAND, db);
    write_reg(CFG_FAST_STEP, fs);
    write_reg(CFG_SLOW_STEP, ss);
    write_reg(CFG_BRAKE_STEP, ds);
    write_reg(CFG_FAST_LIMIT, fl);
    write_reg(CFG_TURN_GAIN, tg);
  endtask

  // holds off until the pipe is empty and every duty set has been checked
  task automatic wait_drained();
    @(negedge clk_i);
    while (stick_queue.size() != 0 || in_valid_i || duty_forecast.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic add_stick(input logic [15:0] v, input logic [15:0] h,
                           input logic [1:0] l, input int reps);
    stick_t s;
    s.vert = v;
    s.horiz = h;
    s.link = l;
    repeat (reps) stick_queue.push_back(s);
  endtask

  function automatic logic [15:0] pick_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 5))
        0: return 16'd0;
        1: return 16'hFFFF;
        2: return 16'd32767;
        3: return 16'd32768;
        4: return 16'd1;
        default: return 16'hFFFE;
      endcase
    end
    if (r < 40) return 16'(30768 + int'($urandom_range(0, 4000)));
    return 16'($urandom);
  endfunction

  // mostly held stick positions so the ramps travel far, plus loose noise
  task automatic queue_random(input int n);
    stick_t s, t;
    int added, hold_len, r, k;
    added = 0;
    while (added < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        s.vert = pick_axis();
        s.horiz = pick_axis();
        hold_len = $urandom_range(3, 50);
        for (k = 0; k < hold_len && added < n; k++) begin
          t = s;
          r = $urandom_range(0, 99);
          if (r < 84) t.link = LINK_FRESH;
          else if (r < 94) t.link = LINK_HOLD;
          else if (r < 98) t.link = LINK_LOST;
          else t.link = LINK_SPARE;
          if (t.link != LINK_FRESH) begin
            t.vert = 16'($urandom);
            t.horiz = 16'($urandom);
          end
          stick_queue.push_back(t);
          added++;
        end
      end else begin
        s.vert = 16'($urandom);
        s.horiz = 16'($urandom);
        s.link = 2'($urandom_range(0, 3));
        stick_queue.push_back(s);
        added++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: full throws, reversal, hold, lost links, deadband edges
    add_stick(16'd0, 16'hFFFF, LINK_FRESH, 3);
    add_stick(16'd32768, 16'd32768, LINK_HOLD, 2);
    add_stick(16'hFFFF, 16'd0, LINK_FRESH, 2);
    add_stick(16'd31225, 16'd34310, LINK_FRESH, 1);
    add_stick(16'd31226, 16'd34309, LINK_FRESH, 1);
    add_stick(16'd0, 16'd0, LINK_LOST, 2);
    add_stick(16'hFFFF, 16'hFFFF, LINK_SPARE, 2);
    add_stick(16'd32767, 16'd32768, LINK_FRESH, 2);
    add_stick(16'd0, 16'd0, LINK_FRESH, 3);
    add_stick(16'hAAAA, 16'h5555, LINK_FRESH, 1);
    add_stick(16'h5555, 16'hAAAA, LINK_FRESH, 1);
    add_stick(16'hFFFF, 16'hFFFF, LINK_FRESH, 2);
    wait_drained();
    queue_random(80);
    wait_drained();

    load_setting(16'd0, 16'd16383, 16'd16383, 16'd16383, 16'd0, 16'd255);
    queue_random(40);
    wait_drained();
    queue_random(40);
    wait_drained();

    // frozen ramps: nothing can move
    load_setting(16'd255, 16'd0, 16'd0, 16'd0, 16'd65280, 16'd0);
    queue_random(30);
    wait_drained();

    load_setting(16'd12, 16'd4000, 16'd1000, 16'd6000, 16'd30000, 16'd200);
    queue_random(60);
    wait_drained();
    queue_random(60);
    wait_drained();

    repeat (2) begin
      load_setting(16'($urandom_range(0, 40)), 16'($urandom_range(1, 9000)),
                   16'($urandom_range(1, 3000)), 16'($urandom_range(1, 12000)),
                   16'($urandom_range(0, 65280)), 16'($urandom_range(0, 255)));
      queue_random(70);
      wait_drained();
      queue_random(70);
      wait_drained();
    end

    load_setting(16'(DEADBAND_RST), 16'(FAST_STEP_RST), 16'(SLOW_STEP_RST),
                 16'(BRAKE_STEP_RST), FAST_LIMIT_RST, 16'(TURN_GAIN_RST));
    queue_random(60);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (duty_forecast.size() != 0) begin
      $display("ERROR: %0d duty sets never arrived", duty_forecast.size());
      fail_count += duty_forecast.size();
    end
    $display("Run: %0d stick samples, %0d duty sets checked, %0d register writes",
             sticks_taken, duties_checked, cfg_writes);
    $display("Run: ramp peak %0d (Q.8), %0d saturated wheel values, %0d failures",
             ramp_peak, saturated_sides, fail_count);
    if (fail_count == 0) begin
      $display("** joystick_ramped_differential_drive: PASSED **");
    end else begin
      $display("** joystick_ramped_differential_drive: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/jrdd_pkg.sv
rtl/jrdd_axis_map.sv
rtl/jrdd_ramp.sv
rtl/jrdd_mixer.sv
rtl/joystick_ramped_differential_drive.sv
tb/tb.sv
